FILE: rtl/pbf_pkg.sv
// shared constants, types and state codes for the power-of-two best-fit block pool
package pbf_pkg;

	// table geometry
	localparam int POOL_ENTRIES = 64;
	localparam int IDX_W        = $clog2(POOL_ENTRIES);

	// field widths
	localparam int HANDLE_W = 6;
	localparam int BYTES_W  = 28;
	localparam int DTYPE_W  = 4;
	localparam int DEV_W    = 2;
	localparam int EBYTES_W = 4;
	localparam int COUNT_W  = 25;
	localparam int STATUS_W = 3;

	// exponent of the rounded element count, up to COUNT_W
	localparam int EXP_W  = $clog2(COUNT_W + 1);
	// unsaturated byte size: element size shifted by the exponent
	localparam int WIDE_W = EBYTES_W + COUNT_W;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_REUSED   = 3'd0,
		STAT_NEW      = 3'd1,
		STAT_RETURNED = 3'd2,
		STAT_NOT_BUSY = 3'd3,
		STAT_FULL     = 3'd4
	} pbf_status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_SCAN,
		S_LAST,
		S_DECIDE,
		S_RET_RD,
		S_RET_CHK,
		S_RESULT
	} pbf_state_t;

	// one block descriptor as held in the table memory
	typedef struct packed {
		logic [BYTES_W-1:0] bytes;
		logic [DTYPE_W-1:0] dtype;
		logic [DEV_W-1:0]   device;
	} pbf_desc_t;

	// size unit status toward the sequencer
	typedef struct packed {
		logic               done;
		logic [BYTES_W-1:0] need;
	} pbf_need_t;

endpackage

FILE: rtl/pbf_if.sv
// request and response channel interfaces of the block pool

interface pbf_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [pbf_pkg::DEV_W-1:0]      device_id;
	logic [pbf_pkg::DTYPE_W-1:0]    dtype_code;
	logic [pbf_pkg::EBYTES_W-1:0]   elem_bytes;
	logic [pbf_pkg::COUNT_W-1:0]    elem_count;
	logic [pbf_pkg::HANDLE_W-1:0]   block_handle;

	modport source (
		output valid, cmd, device_id, dtype_code, elem_bytes, elem_count, block_handle,
		input  ready
	);
	modport sink (
		input  valid, cmd, device_id, dtype_code, elem_bytes, elem_count, block_handle,
		output ready
	);
endinterface

interface pbf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [pbf_pkg::STATUS_W-1:0]   status;
	logic [pbf_pkg::HANDLE_W-1:0]   handle_out;
	logic [pbf_pkg::BYTES_W-1:0]    block_bytes;

	modport source (
		output valid, status, handle_out, block_bytes,
		input  ready
	);
	modport sink (
		input  valid, status, handle_out, block_bytes,
		output ready
	);
endinterface

FILE: rtl/pbf_size_unit.sv
// iterative unit that rounds the element count to a power of two and scales it to bytes
module pbf_size_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pbf_pkg::COUNT_W-1:0]  count,
	input  logic [pbf_pkg::EBYTES_W-1:0] ebytes,
	output pbf_pkg::pbf_need_t           res
);

	logic                          run_q;
	logic                          done_q;
	logic [pbf_pkg::EXP_W-1:0]     exp_q;
	logic [pbf_pkg::COUNT_W-1:0]   count_q;
	logic [pbf_pkg::EBYTES_W-1:0]  eb_q;
	logic [pbf_pkg::BYTES_W-1:0]   need_q;

	logic [pbf_pkg::COUNT_W:0]     pow;
	logic                          below;
	logic [pbf_pkg::WIDE_W-1:0]    wide;
	logic [pbf_pkg::BYTES_W-1:0]   sat;

	// one doubling compare per cycle, then shift the element size by the exponent
	always_comb begin
		pow   = (pbf_pkg::COUNT_W+1)'(1) << exp_q;
		below = pow < {1'b0, count_q};
		wide  = pbf_pkg::WIDE_W'(eb_q) << exp_q;
		sat   = (wide > pbf_pkg::WIDE_W'(pbf_pkg::BYTES_MAX)) ? pbf_pkg::BYTES_MAX
			: wide[pbf_pkg::BYTES_W-1:0];
	end

	// loop control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && !below) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands and result
	always_ff @(posedge clk) begin
		if (start) begin
			count_q <= count;
			eb_q    <= ebytes;
			exp_q   <= pbf_pkg::EXP_W'(1);
		end else if (run_q) begin
			if (below) begin
				exp_q <= exp_q + 1'b1;
			end else begin
				need_q <= sat;
			end
		end
	end

	assign res.done = done_q;
	assign res.need = need_q;

endmodule

FILE: rtl/pow2_best_fit_block_pool_top.sv
// top level of the power-of-two best-fit block pool: sequencer, descriptor table and scan
//
// Block pool with a table of POOL_ENTRIES descriptors. One item is handled at a time:
// req.ready is high only while the sequencer is idle. A request (cmd 0) first rounds its
// element count in the size unit, one power of two per cycle, then scans the descriptor
// memory one entry per cycle, then decides and writes. A return (cmd 1) reads the
// descriptor of its handle and checks it before its result is given.
// The result sits in an output register so the next request can be taken while it waits.
// Descriptor contents are not cleared at reset; valid and busy flags are, so no clearing
// pass is needed.
module pow2_best_fit_block_pool_top (
	input  logic       clk,
	input  logic       arst_n,
	pbf_req_if.sink    req,
	pbf_rsp_if.source  rsp
);

	localparam int IW = pbf_pkg::IDX_W;
	localparam int N  = pbf_pkg::POOL_ENTRIES;

	pbf_pkg::pbf_state_t state_q, state_d;

	// latched request
	logic                          cmd_q;
	logic [pbf_pkg::DEV_W-1:0]     dev_q;
	logic [pbf_pkg::DTYPE_W-1:0]   dtype_q;
	logic [pbf_pkg::HANDLE_W-1:0]  handle_q;

	// flags per slot
	logic [N-1:0] valid_q;
	logic [N-1:0] busy_q;

	// descriptor memory
	pbf_pkg::pbf_desc_t desc_mem [N];
	pbf_pkg::pbf_desc_t desc_rd_s1;
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	pbf_pkg::pbf_desc_t mem_wd;
	logic [IW-1:0]      rd_addr;

	// scan state
	logic [IW-1:0]               rd_q;
	logic                        scan_vld_s1;
	logic [IW-1:0]               scan_idx_s1;
	logic                        found_q;
	logic [IW-1:0]               best_q;
	logic [pbf_pkg::BYTES_W-1:0] best_bytes_q;
	logic                        empty_found_q;
	logic [IW-1:0]               empty_q;

	// pending and output results
	pbf_pkg::pbf_status_t          res_status_q;
	logic [pbf_pkg::HANDLE_W-1:0]  res_handle_q;
	logic [pbf_pkg::BYTES_W-1:0]   res_bytes_q;
	logic                          out_vld_q;
	pbf_pkg::pbf_status_t          out_status_q;
	logic [pbf_pkg::HANDLE_W-1:0]  out_handle_q;
	logic [pbf_pkg::BYTES_W-1:0]   out_bytes_q;

	logic               accept;
	logic               sz_start;
	pbf_pkg::pbf_need_t sz_res;
	logic               scan_hit;
	logic               scan_empty;
	logic               reuse;
	logic               take_new;
	logic [IW-1:0]      hidx;
	logic               hok;
	logic               ret_ok;
	logic               out_load;

	assign accept = req.valid && req.ready;

	pbf_size_unit u_size (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sz_start),
		.count  (req.elem_count),
		.ebytes (req.elem_bytes),
		.res    (sz_res)
	);

	// compare of the entry read last cycle against the running best
	always_comb begin
		scan_hit = scan_vld_s1 && valid_q[scan_idx_s1] && !busy_q[scan_idx_s1]
			&& (desc_rd_s1.dtype == dtype_q) && (desc_rd_s1.device == dev_q)
			&& (desc_rd_s1.bytes >= sz_res.need)
			&& (!found_q || (desc_rd_s1.bytes <= best_bytes_q));
		scan_empty = scan_vld_s1 && !valid_q[scan_idx_s1] && !empty_found_q;
	end

	// decision and return checks
	always_comb begin
		reuse    = found_q && ({1'b0, best_bytes_q} < {sz_res.need, 1'b0});
		take_new = !reuse && empty_found_q;
		hidx     = IW'(handle_q);
		hok      = 32'(handle_q) < N;
		ret_ok   = hok && valid_q[hidx] && busy_q[hidx];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbf_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == pbf_pkg::CMD_FREE) ? pbf_pkg::S_RET_RD
						: pbf_pkg::S_ROUND;
				end
			end
			pbf_pkg::S_ROUND: begin
				if (sz_res.done) begin
					state_d = pbf_pkg::S_SCAN;
				end
			end
			pbf_pkg::S_SCAN: begin
				if (rd_q == IW'(N - 1)) begin
					state_d = pbf_pkg::S_LAST;
				end
			end
			pbf_pkg::S_LAST:    state_d = pbf_pkg::S_DECIDE;
			pbf_pkg::S_DECIDE:  state_d = pbf_pkg::S_RESULT;
			pbf_pkg::S_RET_RD:  state_d = pbf_pkg::S_RET_CHK;
			pbf_pkg::S_RET_CHK: state_d = pbf_pkg::S_RESULT;
			pbf_pkg::S_RESULT: begin
				if (out_load) begin
					state_d = pbf_pkg::S_IDLE;
				end
			end
			default: state_d = pbf_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready     = (state_q == pbf_pkg::S_IDLE);
		sz_start      = accept && (req.cmd == pbf_pkg::CMD_ALLOC);
		rd_addr       = (state_q == pbf_pkg::S_SCAN) ? rd_q : hidx;
		mem_we        = (state_q == pbf_pkg::S_DECIDE) && take_new;
		mem_wa        = empty_q;
		mem_wd.bytes  = sz_res.need;
		mem_wd.dtype  = dtype_q;
		mem_wd.device = dev_q;
		out_load      = (state_q == pbf_pkg::S_RESULT) && (!out_vld_q || rsp.ready);
	end

	// descriptor memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			desc_mem[mem_wa] <= mem_wd;
		end
		desc_rd_s1 <= desc_mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pbf_pkg::S_IDLE;
			rd_q          <= '0;
			scan_vld_s1   <= 1'b0;
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
			valid_q       <= '0;
			busy_q        <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == pbf_pkg::S_SCAN);
			if (state_q == pbf_pkg::S_SCAN && rd_q != IW'(N - 1)) begin
				rd_q <= rd_q + 1'b1;
			end else begin
				rd_q <= '0;
			end
			if (accept) begin
				found_q       <= 1'b0;
				empty_found_q <= 1'b0;
			end else begin
				if (scan_hit) begin
					found_q <= 1'b1;
				end
				if (scan_empty) begin
					empty_found_q <= 1'b1;
				end
			end
			// slot flag updates
			if (state_q == pbf_pkg::S_DECIDE) begin
				if (reuse) begin
					busy_q[best_q] <= 1'b1;
				end else if (take_new) begin
					valid_q[empty_q] <= 1'b1;
					busy_q[empty_q]  <= 1'b1;
				end
			end
			if (state_q == pbf_pkg::S_RET_CHK && ret_ok) begin
				busy_q[hidx] <= 1'b0;
			end
			// output register
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			dev_q    <= req.device_id;
			dtype_q  <= req.dtype_code;
			handle_q <= req.block_handle;
		end
		scan_idx_s1 <= rd_q;
		if (scan_hit) begin
			best_q       <= scan_idx_s1;
			best_bytes_q <= desc_rd_s1.bytes;
		end
		if (scan_empty) begin
			empty_q <= scan_idx_s1;
		end
		// pending result
		if (state_q == pbf_pkg::S_DECIDE) begin
			if (reuse) begin
				res_status_q <= pbf_pkg::STAT_REUSED;
				res_handle_q <= pbf_pkg::HANDLE_W'(best_q);
				res_bytes_q  <= best_bytes_q;
			end else if (take_new) begin
				res_status_q <= pbf_pkg::STAT_NEW;
				res_handle_q <= pbf_pkg::HANDLE_W'(empty_q);
				res_bytes_q  <= sz_res.need;
			end else begin
				res_status_q <= pbf_pkg::STAT_FULL;
				res_handle_q <= '0;
				res_bytes_q  <= '0;
			end
		end
		if (state_q == pbf_pkg::S_RET_CHK) begin
			res_handle_q <= handle_q;
			if (ret_ok) begin
				res_status_q <= pbf_pkg::STAT_RETURNED;
				res_bytes_q  <= desc_rd_s1.bytes;
			end else begin
				res_status_q <= pbf_pkg::STAT_NOT_BUSY;
				res_bytes_q  <= '0;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_bytes_q  <= res_bytes_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.handle_out  = out_handle_q;
	assign rsp.block_bytes = out_bytes_q;

	// a slot is only ever busy while it holds a descriptor
	a_busy_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & ~valid_q) == '0)
		else $error("busy slot without a descriptor");

	// a new descriptor only goes into an empty slot
	a_new_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pbf_pkg::S_DECIDE && take_new) |-> !valid_q[empty_q])
		else $error("new descriptor written over a valid slot");

	// a reused block is marked busy after the decision
	a_reuse_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pbf_pkg::S_DECIDE && reuse) |=> busy_q[$past(best_q)])
		else $error("reused block not marked busy");

	// the size unit finishes only while the sequencer waits for it
	a_size_done_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		sz_res.done |-> (state_q == pbf_pkg::S_ROUND && cmd_q == pbf_pkg::CMD_ALLOC))
		else $error("size result outside the rounding step");

endmodule
